// ----- design/lrmmp_pkg.sv -----
// ----------------------------------------------------------------------------
// lrmmp_pkg
// Shared types and constants for the recurrence-term matrix power block.
// ----------------------------------------------------------------------------
package lrmmp_pkg;

  typedef logic [3:0] nib_t;

  // Companion matrix, row major
  localparam logic [15:0] COMPANION = 16'b0100_0010_0001_1101;

  // Starting terms f(0..4)
  localparam nib_t SEED_TERMS [5] = '{4'd0, 4'd2, 4'd4, 4'd6, 4'd9};

  // Weights applied to the first row of the power
  localparam nib_t ROW_WEIGHTS [4] = '{4'd9, 4'd6, 4'd4, 4'd2};

  // Matrix operations run by the sequencer
  typedef enum logic [1:0] {
    OP_RB  = 2'd0,
    OP_BB  = 2'd1,
    OP_FIN = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INIT = 8'b0000_0010,
    S_LOOP = 8'b0000_0100,
    S_LD   = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_COPY = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_e;

  // Control handshake with the modular multiplier
  typedef struct packed {
    logic start;
    logic done;
  } mm_ctrl_t;

endpackage

// ----- design/lrmmp_modmul.sv -----
// ----------------------------------------------------------------------------
// lrmmp_modmul
// Bit-serial modular multiplier: a * b mod m, one bit of a per cycle.
// ----------------------------------------------------------------------------
module lrmmp_modmul #(
  parameter int MOD_WIDTH = 16,
  parameter int A_WIDTH   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [A_WIDTH-1:0]   a_i,
  input  logic [MOD_WIDTH-1:0] b_i,
  input  logic [MOD_WIDTH-1:0] m_i,
  output logic                 done_o,
  output logic [MOD_WIDTH-1:0] prod_o
);
  localparam int CW = $clog2(A_WIDTH + 1);

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic [A_WIDTH-1:0]   a_q;
  logic [MOD_WIDTH-1:0] b_q, acc_q, acc_d;
  logic [MOD_WIDTH:0]   dbl, dbl_r, sum, sum_r;

  // Double, reduce, conditionally add b, reduce
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    sum   = a_q[A_WIDTH-1] ? dbl_r + {1'b0, b_q} : dbl_r;
    sum_r = (sum >= {1'b0, m_i}) ? sum - {1'b0, m_i} : sum;
    acc_d = sum_r[MOD_WIDTH-1:0];
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(A_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[A_WIDTH-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- design/linear_recurrence_mod_matrix_power.sv -----
// ----------------------------------------------------------------------------
// linear_recurrence_mod_matrix_power
// Term f(n) mod m of f(n)=f(n-1)+f(n-3)+f(n-4) by companion matrix power.
// ----------------------------------------------------------------------------
// One query per transaction: pulse start with term_index and modulus while
// busy is low. busy stays high until the result strobe valid_o, which shows
// term_value for one cycle; the receiver cannot stall it. All arithmetic runs
// on one bit-serial modular multiplier (operand width A = max(MOD_WIDTH,4)),
// each product started from a load state. A 4x4 matrix product is 64 such
// products; an index n>4 needs one squaring per bit of n-4 plus one multiply
// per set bit, then 4 more products for the final weighting. Indices 0..4
// need a single product, and a zero modulus none.
module linear_recurrence_mod_matrix_power #(
  parameter int INDEX_WIDTH = 32,
  parameter int MOD_WIDTH   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [INDEX_WIDTH-1:0] term_index_i,
  input  logic [MOD_WIDTH-1:0]   modulus_i,
  output logic                   valid_o,
  output logic [MOD_WIDTH-1:0]   term_value_o
);
  import lrmmp_pkg::*;

  localparam int AW = (MOD_WIDTH < 4) ? 4 : MOD_WIDTH;

  state_e               state_q;
  op_e                  op_q;
  logic                 seed_q, rb_done_q, one_q;
  logic [2:0]           sd_q;
  logic [1:0]           i_q, j_q, k_q;
  logic [INDEX_WIDTH-1:0] e_q;
  logic [MOD_WIDTH-1:0] m_q, s_q, out_q;
  logic [MOD_WIDTH-1:0] r_q [16];
  logic [MOD_WIDTH-1:0] b_q [16];
  logic [MOD_WIDTH-1:0] t_q [16];

  mm_ctrl_t             mm;
  logic [AW-1:0]        a_sel;
  logic [MOD_WIDTH-1:0] b_sel, prod;
  logic [MOD_WIDTH:0]   sum_w;
  logic [MOD_WIDTH-1:0] sum;
  logic                 last;

  // Select the operand pair for the current product
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    unique case (op_q)
      OP_RB: begin
        a_sel = AW'(r_q[{i_q, k_q}]);
        b_sel = b_q[{k_q, j_q}];
      end
      OP_BB: begin
        a_sel = AW'(b_q[{i_q, k_q}]);
        b_sel = b_q[{k_q, j_q}];
      end
      OP_FIN: begin
        if (seed_q) begin
          a_sel = AW'(SEED_TERMS[sd_q]);
          b_sel = MOD_WIDTH'(one_q);
        end else begin
          a_sel = AW'(ROW_WEIGHTS[k_q]);
          b_sel = r_q[{2'b00, k_q}];
        end
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  // Fold the finished product into the running sum
  always_comb begin
    sum_w = {1'b0, s_q} + {1'b0, prod};
    if (sum_w >= {1'b0, m_q}) sum_w = sum_w - {1'b0, m_q};
    sum  = sum_w[MOD_WIDTH-1:0];
    last = (op_q == OP_FIN) ? (seed_q || k_q == 2'd3) : (k_q == 2'd3);
  end

  assign mm.start = (state_q == S_LD);

  lrmmp_modmul #(.MOD_WIDTH(MOD_WIDTH), .A_WIDTH(AW)) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm.start),
    .a_i    (a_sel),
    .b_i    (b_sel),
    .m_i    (m_q),
    .done_o (mm.done),
    .prod_o (prod)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_FIN;
      seed_q    <= 1'b0;
      rb_done_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            k_q <= '0;
            i_q <= '0;
            j_q <= '0;
            if (modulus_i == '0) begin
              state_q <= S_DONE;
            end else if (term_index_i <= INDEX_WIDTH'(4)) begin
              seed_q  <= 1'b1;
              op_q    <= OP_FIN;
              state_q <= S_LD;
            end else begin
              seed_q  <= 1'b0;
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          rb_done_q <= 1'b0;
          state_q   <= S_LOOP;
        end
        S_LOOP: begin
          k_q <= '0;
          i_q <= '0;
          j_q <= '0;
          if (e_q == '0) op_q <= OP_FIN;
          else if (e_q[0] && !rb_done_q) op_q <= OP_RB;
          else op_q <= OP_BB;
          state_q <= S_LD;
        end
        S_LD: state_q <= S_MUL;
        S_MUL: begin
          if (mm.done) begin
            if (!last) begin
              k_q     <= k_q + 2'd1;
              state_q <= S_LD;
            end else if (op_q == OP_FIN) begin
              state_q <= S_DONE;
            end else begin
              k_q <= '0;
              {i_q, j_q} <= {i_q, j_q} + 4'd1;
              state_q <= ({i_q, j_q} == 4'hF) ? S_COPY : S_LD;
            end
          end
        end
        S_COPY: begin
          rb_done_q <= (op_q == OP_RB);
          state_q   <= S_LOOP;
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Matrices, exponent, sum and result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          m_q   <= modulus_i;
          one_q <= (modulus_i != MOD_WIDTH'(1));
          sd_q  <= term_index_i[2:0];
          e_q   <= term_index_i - INDEX_WIDTH'(4);
          s_q   <= '0;
          out_q <= '0;
        end
      end
      S_INIT: begin
        for (int x = 0; x < 16; x++) begin
          r_q[x] <= MOD_WIDTH'(one_q && (x % 5 == 0));
          b_q[x] <= MOD_WIDTH'(one_q && COMPANION[x]);
        end
      end
      S_LOOP: s_q <= '0;
      S_MUL: begin
        if (mm.done) begin
          if (!last) begin
            s_q <= sum;
          end else if (op_q == OP_FIN) begin
            out_q <= sum;
          end else begin
            t_q[{i_q, j_q}] <= sum;
            s_q <= '0;
          end
        end
      end
      S_COPY: begin
        if (op_q == OP_RB) begin
          for (int x = 0; x < 16; x++) r_q[x] <= t_q[x];
        end else begin
          for (int x = 0; x < 16; x++) b_q[x] <= t_q[x];
          e_q <= e_q >> 1;
        end
      end
      default: ;
    endcase
  end

  assign busy         = (state_q != S_IDLE);
  assign valid_o      = (state_q == S_DONE);
  assign term_value_o = out_q;

endmodule

// ----- design/lrmmp_chk.sv -----
// ----------------------------------------------------------------------------
// lrmmp_chk
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
module lrmmp_chk #(
  parameter int MOD_WIDTH   = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic [MOD_WIDTH-1:0]   modulus_i,
  input logic                   valid_o,
  input logic [MOD_WIDTH-1:0]   term_value_o
);
  // Accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // Result strobe only while a transaction is open
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result outside transaction");

  // One strobe per transaction, then idle
  a_valid_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy && !valid_o) else $error("strobe not single");

  // Zero modulus answers zero at once
  a_zero_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && modulus_i == '0 |=> valid_o && term_value_o == '0)
    else $error("zero modulus result wrong");

endmodule

bind linear_recurrence_mod_matrix_power lrmmp_chk #(
  .MOD_WIDTH  (MOD_WIDTH)
) u_lrmmp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .modulus_i   (modulus_i),
  .valid_o     (valid_o),
  .term_value_o(term_value_o)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks recurrence terms f(n) mod m from the matrix power block against a
// behavioral matrix power. Directed corner queries, then random queries with
// mostly small indices, under random sender gaps and one full drain pause.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IW = 32;
  localparam int MW = 16;
  localparam int STALL_LIMIT = 400000;

  typedef longint unsigned mat_t [4][4];

  typedef struct {
    logic [IW-1:0] term_index;
    logic [MW-1:0] modulus;
    bit            drain_first;
  } query_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [IW-1:0] term_index_i = '0;
  logic [MW-1:0] modulus_i = '0;
  logic          valid_o;
  logic [MW-1:0] term_value_o;

  query_t        query_q[$];
  logic [MW-1:0] term_q[$];
  int            error_count = 0;
  int            sent_count = 0;
  int            stall_cycles = 0;

  linear_recurrence_mod_matrix_power #(
    .INDEX_WIDTH(IW),
    .MOD_WIDTH(MW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .term_index_i(term_index_i),
    .modulus_i   (modulus_i),
    .valid_o     (valid_o),
    .term_value_o(term_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Multiply two matrices, reducing every entry modulo m
  function automatic mat_t mat_mul_mod(mat_t x, mat_t y, longint unsigned m);
    mat_t            r;
    longint unsigned acc;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += (x[i][k] % m) * (y[k][j] % m);
        r[i][j] = acc % m;
      end
    end
    return r;
  endfunction

  // Expected term value for one query
  function automatic logic [MW-1:0] recurrence_term(logic [IW-1:0] n, logic [MW-1:0] mod);
    longint unsigned m = mod;
    longint unsigned p;
    longint unsigned acc;
    longint unsigned seeds [5] = '{0, 2, 4, 6, 9};
    longint unsigned weights [4] = '{9, 6, 4, 2};
    mat_t            acc_m;
    mat_t            base;
    mat_t            comp = '{'{1, 0, 1, 1}, '{1, 0, 0, 0}, '{0, 1, 0, 0}, '{0, 0, 1, 0}};
    if (m == 0) return '0;
    if (n <= 4) return MW'(seeds[n] % m);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc_m[i][j] = (i == j) ? 1 % m : 0;
        base[i][j]  = comp[i][j] % m;
      end
    end
    p = longint'(n) - 4;
    while (p != 0) begin
      if (p[0]) acc_m = mat_mul_mod(acc_m, base, m);
      base = mat_mul_mod(base, base, m);
      p >>= 1;
    end
    acc = 0;
    for (int j = 0; j < 4; j++) acc += (weights[j] * acc_m[0][j]) % m;
    return MW'(acc % m);
  endfunction

  task automatic add_query(logic [IW-1:0] n, logic [MW-1:0] m, bit drain = 1'b0);
    query_t q;
    q.term_index  = n;
    q.modulus     = m;
    q.drain_first = drain;
    query_q.push_back(q);
  endtask

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  // Drive queries; record the expected term on each accepted transaction
  always @(posedge clk_i) begin
    bit            idle_now;
    int            idle_pct;
    if (rst_ni) begin
      if (start && !busy) begin
        term_q.push_back(recurrence_term(term_index_i, modulus_i));
        void'(query_q.pop_front());
        sent_count++;
      end
      if (sent_count < 45) idle_pct = 22;
      else if (sent_count < 95) idle_pct = 56;
      else idle_pct = 0;
      idle_now = ($urandom_range(0, 99) < idle_pct);
      if (start && busy) begin
        // hold the current transaction
      end else if (query_q.size() == 0 || idle_now ||
                   (query_q[0].drain_first && term_q.size() != 0)) begin
        start <= 1'b0;
      end else begin
        start        <= 1'b1;
        term_index_i <= query_q[0].term_index;
        modulus_i    <= query_q[0].modulus;
      end
    end
  end

  // Check each result strobe against the oldest expected term
  always @(posedge clk_i) begin
    logic [MW-1:0] want;
    if (rst_ni && valid_o) begin
      if (term_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", term_value_o));
      end else begin
        want = term_q.pop_front();
        if (term_value_o !== want)
          report_mismatch($sformatf("term_value got %0d want %0d", term_value_o, want));
      end
    end
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int            r;
    logic [IW-1:0] n;
    logic [MW-1:0] m;
    // directed corners: table indices, first matrix indices, extremes
    add_query(0, 65535);
    add_query(1, 7);
    add_query(2, 3);
    add_query(3, 5);
    add_query(4, 65535);
    add_query(4, 2);
    add_query(5, 65535);
    add_query(6, 1000);
    add_query(7, 1);
    add_query(5, 1);
    add_query(32'hFFFF_FFFF, 0);
    add_query(3, 0);
    add_query(20, 65521);
    add_query(32'hFFFF_FFFF, 65535);
    add_query(32'h8000_0004, 32768);
    add_query(37, 2);
    add_query(12, 16'h5555);
    add_query(13, 16'hAAAA);
    repeat (12) @(posedge clk_i);
    rst_ni = 1'b1;
    // random queries, mostly small indices to bound run time
    for (int i = 0; i < 122; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) n = $urandom_range(0, 4);
      else if (r < 95) n = $urandom_range(5, 48);
      else n = $urandom;
      m = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 20) : $urandom_range(1, 65535);
      add_query(n, m, i == 60);
    end
    wait (query_q.size() == 0 && term_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
